// ===== hw/rtl/dds_pkg.sv =====
package dds_pkg;

   // Sizes of the sweep cell datapath.
   localparam int NUM_DIRECTIONS = 16;
   localparam int FRAC_BITS      = 16;
   localparam int DIR_W          = 4;
   localparam int FLUX_W         = 32;
   localparam int COEF_W         = 31;
   localparam int DIR_IDX_W      = $clog2(NUM_DIRECTIONS);
   localparam int NUM_W          = 2 * FLUX_W;
   localparam int DIV_STEPS      = FLUX_W;
   localparam int STEP_CNT_W     = $clog2(DIV_STEPS);

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   localparam logic CMD_BOUNDARY = 1'b0;
   localparam logic CMD_CELL     = 1'b1;

   // Saturation limits of a signed flux value.
   localparam logic signed [FLUX_W-1:0] FLUX_MAX = {1'b0, {(FLUX_W-1){1'b1}}};
   localparam logic signed [FLUX_W-1:0] FLUX_MIN = {1'b1, {(FLUX_W-1){1'b0}}};

   typedef struct packed {
      logic                     command;
      logic [DIR_W-1:0]         direction;
      logic signed [FLUX_W-1:0] boundary_flux;
      logic [COEF_W-1:0]        mu_over_step;
      logic [COEF_W-1:0]        half_sigma_total;
      logic signed [FLUX_W-1:0] fixed_source;
      logic signed [FLUX_W-1:0] scatter_source;
   } req_type;

   typedef struct packed {
      logic signed [FLUX_W-1:0] outgoing_flux;
      logic                     divide_error;
   } rsp_type;

   // One classified item as the front part hands it to the back part.
   typedef struct packed {
      logic                     command;
      logic [DIR_W-1:0]         direction;
      logic signed [FLUX_W-1:0] boundary_flux;
      logic signed [FLUX_W-1:0] coef_diff;
      logic [FLUX_W-1:0]        denom;
      logic signed [FLUX_W:0]   src_sum;
   } work_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage

// ===== hw/rtl/dds_if.sv =====
interface dds_req_if;
   logic              valid;
   logic              ready;
   dds_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dds_rsp_if;
   logic              valid;
   logic              ready;
   dds_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dds_front.sv =====
module dds_front (
   dds_req_if.sink                    req_ch,
   input  dds_pkg::queue_status_type  q_stat,
   output logic                       push,
   output dds_pkg::work_type          push_work
);

   // Take an item whenever the queue has room.
   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full;

   // Form the coefficients and source sum that do not depend on the running flux.
   always_comb begin
      push_work.command       = req_ch.payload.command;
      push_work.direction     = req_ch.payload.direction;
      push_work.boundary_flux = req_ch.payload.boundary_flux;
      push_work.coef_diff     = signed'({1'b0, req_ch.payload.mu_over_step})
                              - signed'({1'b0, req_ch.payload.half_sigma_total});
      push_work.denom         = {1'b0, req_ch.payload.mu_over_step}
                              + {1'b0, req_ch.payload.half_sigma_total};
      push_work.src_sum       = (dds_pkg::FLUX_W + 1)'(req_ch.payload.fixed_source)
                              + (dds_pkg::FLUX_W + 1)'(req_ch.payload.scatter_source);
   end

endmodule

// ===== hw/rtl/dds_queue.sv =====
module dds_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dds_pkg::work_type          push_work,
   input  logic                       pop,
   output dds_pkg::work_type          head_work,
   output dds_pkg::queue_status_type  q_stat
);

   dds_pkg::work_type                  entry_ff [dds_pkg::QUEUE_DEPTH];
   logic [dds_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dds_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dds_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign head_work    = entry_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.full  = (count_ff == dds_pkg::QUEUE_CNT_W'(dds_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dds_pkg::QUEUE_PTR_W'(dds_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dds_pkg::QUEUE_PTR_W'(dds_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

// ===== hw/rtl/dds_back.sv =====
module dds_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dds_pkg::queue_status_type  q_stat,
   input  dds_pkg::work_type          head_work,
   output logic                       pop,
   dds_rsp_if.source                  rsp_ch
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_NUM  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_SAT  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                              state_ff, state_in;
   dds_pkg::work_type                       work_ff, work_in;
   logic signed [dds_pkg::NUM_W-1:0]        prod_ff, prod_in;
   logic [dds_pkg::FLUX_W-1:0]              rem_ff, rem_in;
   logic [dds_pkg::FLUX_W-1:0]              quo_ff, quo_in;
   logic                                    neg_ff, neg_in;
   logic                                    ovf_ff, ovf_in;
   logic [dds_pkg::STEP_CNT_W-1:0]          step_ff, step_in;
   logic signed [dds_pkg::FLUX_W-1:0]       result_ff, result_in;
   logic                                    err_ff, err_in;
   logic                                    out_valid_ff, out_valid_in;
   dds_pkg::rsp_type                        out_data_ff, out_data_in;
   logic signed [dds_pkg::FLUX_W-1:0]       flux_ff [dds_pkg::NUM_DIRECTIONS];

   logic                                    dir_in_range;
   logic [dds_pkg::DIR_IDX_W-1:0]           dir_idx;
   logic signed [dds_pkg::FLUX_W-1:0]       psi;
   logic signed [dds_pkg::NUM_W-1:0]        numer;
   logic [dds_pkg::NUM_W-1:0]               numer_mag;
   logic [dds_pkg::FLUX_W:0]                trial;
   logic                                    trial_ge;
   logic                                    out_free;
   logic                                    flux_wr_en;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   assign pop      = (state_ff == ST_IDLE) && !q_stat.empty;
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Running flux lookup; directions past the table read as zero.
   assign dir_in_range = (int'(work_ff.direction) < dds_pkg::NUM_DIRECTIONS);
   assign dir_idx      = dds_pkg::DIR_IDX_W'(work_ff.direction);
   assign psi          = dir_in_range ? flux_ff[dir_idx] : '0;

   // Numerator with twice the fraction bits, and its magnitude.
   assign numer     = prod_ff
                    + (dds_pkg::NUM_W'(work_ff.src_sum) <<< dds_pkg::FRAC_BITS);
   assign numer_mag = numer[dds_pkg::NUM_W-1] ? (~numer + 1'b1) : numer;

   // One restoring division step.
   assign trial    = {rem_ff, quo_ff[dds_pkg::FLUX_W-1]};
   assign trial_ge = (trial >= {1'b0, work_ff.denom});

   assign flux_wr_en = (state_ff == ST_DONE) && out_free && dir_in_range;

   // Sequencer of the back part.
   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      result_in    = result_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               work_in = head_work;
               err_in  = 1'b0;
               if (head_work.command == dds_pkg::CMD_BOUNDARY) begin
                  result_in = head_work.boundary_flux;
                  state_in  = ST_DONE;
               end else if (head_work.denom == '0) begin
                  result_in = '0;
                  err_in    = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = work_ff.coef_diff * psi;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            neg_in   = numer[dds_pkg::NUM_W-1];
            rem_in   = numer_mag[dds_pkg::NUM_W-1:dds_pkg::FLUX_W];
            quo_in   = numer_mag[dds_pkg::FLUX_W-1:0];
            ovf_in   = (numer_mag[dds_pkg::NUM_W-1:dds_pkg::FLUX_W] >= work_ff.denom);
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? dds_pkg::FLUX_W'(trial - {1'b0, work_ff.denom})
                               : trial[dds_pkg::FLUX_W-1:0];
            quo_in  = {quo_ff[dds_pkg::FLUX_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == dds_pkg::STEP_CNT_W'(dds_pkg::DIV_STEPS - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (ovf_ff) begin
               result_in = neg_ff ? dds_pkg::FLUX_MIN : dds_pkg::FLUX_MAX;
            end else if (!neg_ff) begin
               result_in = quo_ff[dds_pkg::FLUX_W-1] ? dds_pkg::FLUX_MAX : signed'(quo_ff);
            end else if (quo_ff > dds_pkg::FLUX_W'(dds_pkg::FLUX_MIN)) begin
               result_in = dds_pkg::FLUX_MIN;
            end else begin
               result_in = signed'(~quo_ff + 1'b1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in              = 1'b1;
               out_data_in.outgoing_flux = result_ff;
               out_data_in.divide_error  = err_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      step_ff     <= step_in;
      result_ff   <= result_in;
      err_ff      <= err_in;
      out_data_ff <= out_data_in;
   end

   // Running flux per direction, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dds_pkg::NUM_DIRECTIONS; i++) begin
            flux_ff[i] <= '0;
         end
      end else if (flux_wr_en) begin
         flux_ff[dir_idx] <= result_ff;
      end
   end

endmodule

// ===== hw/rtl/diamond_difference_sweep_cell_unit.sv =====
// A cell command passes through the multiply, numerator, divide and saturate states of the back part
// before its result is registered; a boundary command or a zero denominator goes straight to the result.
// The back part takes a new item only once the last has left its result state; cells are paced by
// the 32-step radix-2 divider in the back part. Two items queue ahead of the back part.
// Reset (synchronous, active high) clears all running fluxes, the queue and the result valid flag.
module diamond_difference_sweep_cell_unit (
   input  logic        clock,
   input  logic        reset,
   dds_req_if.sink     req_ch,
   dds_rsp_if.source   rsp_ch
);

   dds_pkg::queue_status_type  q_stat;
   dds_pkg::work_type          push_work;
   dds_pkg::work_type          head_work;
   logic                       push;
   logic                       pop;

   // Front part: accepts items and forms their coefficients and source sum.
   dds_front u_front (
      .req_ch    (req_ch),
      .q_stat    (q_stat),
      .push      (push),
      .push_work (push_work)
   );

   // Queue between the front and back parts.
   dds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .head_work (head_work),
      .q_stat    (q_stat)
   );

   // Back part: flux update with multiply and iterative divide.
   dds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_work (head_work),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   // A divide error always comes with a zero flux.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.divide_error |-> rsp_ch.payload.outgoing_flux == '0)
      else $error("divide error with nonzero flux");

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      int'(q_stat.count) <= dds_pkg::QUEUE_DEPTH)
      else $error("queue overfilled");

   // No result is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("result valid after reset");

   // Nothing is pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

endmodule

// ===== sim/sweep_flux_monitor.sv =====
`timescale 1ns / 100ps

// Watches both channels of the sweep cell, predicts every leaving flux and
// compares each result transfer against the oldest prediction.
module sweep_flux_monitor
   import dds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   dds_req_if   req_mon,
   dds_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);

   // Predicted copy of the per-ordinate running flux.
   logic signed [FLUX_W-1:0] ordinate_flux [NUM_DIRECTIONS];

   // Predicted results in transfer order.
   rsp_type awaited_outputs [$];

   // Diamond-difference step: ((b - a) * psi_in + (Q + S) * 2^F) / (b + a),
   // truncated toward zero and saturated to the flux range.
   function automatic rsp_type diamond_step(input req_type item,
                                            input logic signed [FLUX_W-1:0] psi_in);
      logic signed [63:0] b;
      logic signed [63:0] a;
      logic signed [63:0] q;
      logic signed [63:0] s;
      logic signed [63:0] psi;
      logic signed [63:0] den;
      logic signed [63:0] num;
      logic signed [63:0] quo;
      rsp_type            outcome;
      b   = {33'd0, item.mu_over_step};
      a   = {33'd0, item.half_sigma_total};
      q   = {{32{item.fixed_source[FLUX_W-1]}}, item.fixed_source};
      s   = {{32{item.scatter_source[FLUX_W-1]}}, item.scatter_source};
      psi = {{32{psi_in[FLUX_W-1]}}, psi_in};
      den = b + a;
      outcome.divide_error = 1'b0;
      if (den == 0) begin
         // A zero denominator flags the error and yields zero.
         outcome.outgoing_flux = '0;
         outcome.divide_error  = 1'b1;
      end else begin
         num = (b - a) * psi + ((q + s) <<< FRAC_BITS);
         quo = num / den;
         if (quo > FLUX_MAX) begin
            outcome.outgoing_flux = FLUX_MAX;
         end else if (quo < FLUX_MIN) begin
            outcome.outgoing_flux = FLUX_MIN;
         end else begin
            outcome.outgoing_flux = quo[FLUX_W-1:0];
         end
      end
      return outcome;
   endfunction

   // Check result transfers first, then predict from accepted requests.
   always @(posedge clock) begin
      rsp_type                  got;
      rsp_type                  want;
      req_type                  item;
      logic signed [FLUX_W-1:0] psi_in;
      if (reset) begin
         foreach (ordinate_flux[i]) ordinate_flux[i] = '0;
         awaited_outputs.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (awaited_outputs.size() == 0) begin
               $display("%0t: unexpected result transfer, got flux %h error %b",
                        $time, got.outgoing_flux, got.divide_error);
               mismatch_count++;
            end else begin
               want = awaited_outputs.pop_front();
               if (got.outgoing_flux !== want.outgoing_flux) begin
                  $display("%0t: outgoing_flux mismatch, expected %h, got %h",
                           $time, want.outgoing_flux, got.outgoing_flux);
                  mismatch_count++;
               end
               if (got.divide_error !== want.divide_error) begin
                  $display("%0t: divide_error mismatch, expected %b, got %b",
                           $time, want.divide_error, got.divide_error);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            item = req_mon.payload;
            if (item.command == CMD_BOUNDARY) begin
               want.outgoing_flux = item.boundary_flux;
               want.divide_error  = 1'b0;
            end else begin
               // Ordinates past the table read as zero.
               psi_in = (item.direction < NUM_DIRECTIONS) ?
                        ordinate_flux[item.direction] : '0;
               want = diamond_step(item, psi_in);
            end
            if (item.direction < NUM_DIRECTIONS) begin
               ordinate_flux[item.direction] = want.outgoing_flux;
            end
            awaited_outputs.push_back(want);
         end
      end
      outstanding <= awaited_outputs.size();
   end

endmodule

// ===== sim/diamond_difference_sweep_cell_unit_tb.sv =====
`timescale 1ns / 100ps

// Drives the sweep cell with directed corner cases and random sweeps, and
// stalls the result side at random. The monitor does the checking.
module diamond_difference_sweep_cell_unit_tb;
   import dds_pkg::*;

   localparam int ONE          = 1 << FRAC_BITS;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   items_sent;
   int   cycle_count;
   int   quiet_items;
   int   ready_run;

   dds_req_if req_ch ();
   dds_rsp_if rsp_ch ();

   diamond_difference_sweep_cell_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sweep_flux_monitor flux_mon (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Clock generation.
   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result-side backpressure: short stalls mostly, a few long ones, and
   // occasional long stretches of steady readiness.
   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_run    <= 0;
      end else if (ready_run > 0) begin
         ready_run <= ready_run - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_ch.ready <= 1'b1;
            ready_run    <= $urandom_range(0, 4);
         end else if (pick < 85) begin
            rsp_ch.ready <= 1'b0;
            ready_run    <= $urandom_range(0, 3);
         end else if (pick < 93) begin
            rsp_ch.ready <= 1'b0;
            ready_run    <= $urandom_range(10, 50);
         end else begin
            rsp_ch.ready <= 1'b1;
            ready_run    <= $urandom_range(100, 400);
         end
      end
   end

   // Idle cycles ahead of a request; now and then a run of items with none.
   function automatic int pick_gap();
      int pick;
      if (quiet_items > 0) begin
         quiet_items--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         quiet_items = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Signed flux value: full range, small, shifted or an extreme.
   function automatic logic signed [FLUX_W-1:0] rand_flux();
      logic signed [FLUX_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 1 << 21) - (1 << 20);
         2: v = $signed($urandom >> $urandom_range(1, 31)) * ($urandom_range(0, 1) ? 1 : -1);
         3: v = $urandom_range(0, 1) ? FLUX_MAX : FLUX_MIN;
         default: v = $urandom_range(0, 8 * ONE) - 4 * ONE;
      endcase
      return v;
   endfunction

   // Unsigned coefficient across its range.
   function automatic logic [COEF_W-1:0] rand_coef();
      logic [COEF_W-1:0] v;
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = COEF_W'($urandom);
         2: v = '1;
         3: v = COEF_W'($urandom >> $urandom_range(1, 31));
         default: v = COEF_W'($urandom_range(1, 1 << 20));
      endcase
      return v;
   endfunction

   function automatic req_type boundary_item(input logic [DIR_W-1:0] dir,
                                             input logic signed [FLUX_W-1:0] flux);
      req_type item;
      item.command          = CMD_BOUNDARY;
      item.direction        = dir;
      item.boundary_flux    = flux;
      item.mu_over_step     = COEF_W'($urandom);
      item.half_sigma_total = COEF_W'($urandom);
      item.fixed_source     = $urandom;
      item.scatter_source   = $urandom;
      return item;
   endfunction

   function automatic req_type cell_item(input logic [DIR_W-1:0] dir,
                                         input logic [COEF_W-1:0] b,
                                         input logic [COEF_W-1:0] a,
                                         input logic signed [FLUX_W-1:0] q,
                                         input logic signed [FLUX_W-1:0] s);
      req_type item;
      item.command          = CMD_CELL;
      item.direction        = dir;
      item.boundary_flux    = $urandom;
      item.mu_over_step     = b;
      item.half_sigma_total = a;
      item.fixed_source     = q;
      item.scatter_source   = s;
      return item;
   endfunction

   // One cell with coefficients of a plausible mesh most of the time.
   function automatic req_type sweep_cell(input logic [DIR_W-1:0] dir);
      if ($urandom_range(0, 99) < 3) begin
         return cell_item(dir, '0, '0, rand_flux(), rand_flux());
      end
      if ($urandom_range(0, 99) < 80) begin
         return cell_item(dir, COEF_W'($urandom_range(1 << 12, 1 << 20)),
                          COEF_W'($urandom_range(0, 1 << 20)),
                          $urandom_range(0, 4 * ONE) - ONE,
                          $urandom_range(0, 4 * ONE) - ONE);
      end
      return cell_item(dir, rand_coef(), rand_coef(), rand_flux(), rand_flux());
   endfunction

   // Presents one request and holds it until its transfer.
   task automatic transfer_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   initial begin
      int               seq_len;
      logic [DIR_W-1:0] dir;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      items_sent     = 0;
      quiet_items    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed corners. A cell straight after reset sees zero flux.
      transfer_item(cell_item(4'd0, COEF_W'(ONE), COEF_W'(ONE / 2), ONE, ONE / 4));
      // Largest inputs saturate upward, smallest downward.
      transfer_item(boundary_item(4'd1, FLUX_MAX));
      transfer_item(cell_item(4'd1, '1, '0, FLUX_MAX, FLUX_MAX));
      transfer_item(boundary_item(4'd2, FLUX_MIN));
      transfer_item(cell_item(4'd2, '1, '0, FLUX_MIN, FLUX_MIN));
      // Pure absorption on the most negative flux overflows by one.
      transfer_item(boundary_item(4'd3, FLUX_MIN));
      transfer_item(cell_item(4'd3, '0, '1, '0, '0));
      // Zero denominator reports the error and clears the ordinate.
      transfer_item(cell_item(4'd4, '0, '0, ONE, ONE));
      transfer_item(boundary_item(4'd4, 32'sd12345));
      transfer_item(cell_item(4'd4, '0, '0, FLUX_MAX, FLUX_MIN));
      transfer_item(cell_item(4'd4, COEF_W'(ONE), '0, '0, '0));
      // Highest ordinate, smallest step.
      transfer_item(boundary_item(4'd15, -32'sd1));
      transfer_item(cell_item(4'd15, 31'd1, '0, '0, '0));
      transfer_item(cell_item(4'd6, 31'd1, '0, FLUX_MAX, FLUX_MAX));
      // Negative quotient truncates toward zero.
      transfer_item(cell_item(4'd5, 31'd3, 31'd3, -32'sd7, '0));
      // Equal coefficients drop the incoming flux.
      transfer_item(boundary_item(4'd7, '0));
      transfer_item(boundary_item(4'd8, FLUX_MAX));
      transfer_item(cell_item(4'd8, '1, '1, FLUX_MAX, FLUX_MAX));
      transfer_item(cell_item(4'd9, '1, '1, FLUX_MIN, FLUX_MIN));
      // A short ordinary sweep.
      transfer_item(cell_item(4'd1, COEF_W'(2 * ONE), COEF_W'(ONE / 2), ONE, '0));
      transfer_item(cell_item(4'd1, COEF_W'(2 * ONE), COEF_W'(ONE / 2), ONE, -ONE / 2));
      transfer_item(cell_item(4'd7, COEF_W'(ONE / 3), COEF_W'(3 * ONE), -ONE, ONE / 8));

      // Random sweeps: a boundary load and a run of cells on one ordinate,
      // mixed with stray items of any kind.
      while (items_sent < RANDOM_ITEMS + 22) begin
         dir = DIR_W'($urandom_range(0, NUM_DIRECTIONS - 1));
         if ($urandom_range(0, 9) < 7) begin
            transfer_item(boundary_item(dir, rand_flux()));
            seq_len = $urandom_range(1, 10);
            repeat (seq_len) transfer_item(sweep_cell(dir));
         end else if ($urandom_range(0, 1)) begin
            transfer_item(boundary_item(dir, rand_flux()));
         end else begin
            transfer_item(cell_item(dir, rand_coef(), rand_coef(), rand_flux(),
                                    rand_flux()));
         end
      end
      req_ch.valid <= 1'b0;

      // Let the monitor count the last transfer, drain the outstanding
      // results, then give the block time to misbehave.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
